@@ hw/rtl/zlx_pkg.sv @@
`default_nettype none

package zlx_pkg;

    // header framing
    localparam logic [31:0] SIGNATURE   = 32'h504B_0304;
    localparam logic [15:0] HEADER_SKIP = 16'd22;

    // parameter defaults
    localparam int DEF_MAX_ENTRIES = 256;
    localparam int DEF_NAME_LIMIT  = 256;

    // result queue depth, power of two, at least two
    localparam int FIFO_DEPTH = 4;

    // result kinds
    localparam logic KIND_NAME  = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] name_byte;
        logic [7:0] entry_index;
        logic       name_last;
        logic [8:0] entry_count;
    } t_result;

    // up to two results written per accepted byte
    typedef struct packed {
        logic [1:0] cnt;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

`default_nettype wire

@@ hw/rtl/zlx_parser.sv @@
`default_nettype none

module zlx_parser #(
    parameter int MAX_ENTRIES = zlx_pkg::DEF_MAX_ENTRIES,
    parameter int NAME_LIMIT  = zlx_pkg::DEF_NAME_LIMIT
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_take,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_end_of_stream,
    output zlx_pkg::t_push      o_push
);
    import zlx_pkg::*;

    localparam int TW_RAW = $clog2(MAX_ENTRIES + 1);
    localparam int TW     = (TW_RAW > 9) ? TW_RAW : 9;
    localparam logic [16:0]   NAME_LIM = 17'(NAME_LIMIT);
    localparam logic [TW-1:0] MAX_ENT  = TW'(MAX_ENTRIES);

    typedef enum logic [2:0] {
        PH_SCAN, PH_SKIP, PH_NLO, PH_NHI, PH_XLO, PH_XHI, PH_NAME, PH_EXTRA
    } t_phase;

    t_phase        r_phase,    n_phase;
    logic [31:0]   r_window,   n_window;
    logic [2:0]    r_fill,     n_fill;
    logic [15:0]   r_skip,     n_skip;
    logic [15:0]   r_name_len, n_name_len;
    logic [15:0]   r_extra,    n_extra;
    logic [TW-1:0] r_taken,    n_taken;
    logic          r_accepted, n_accepted;

    logic [15:0]   skip_dec;
    logic [TW-1:0] idx_full;
    logic          last;
    logic          name_vld;
    t_result       name_res;
    t_result       count_res;

    always_comb begin
        n_phase    = r_phase;
        n_window   = r_window;
        n_fill     = r_fill;
        n_skip     = r_skip;
        n_name_len = r_name_len;
        n_extra    = r_extra;
        n_taken    = r_taken;
        n_accepted = r_accepted;
        skip_dec   = r_skip - 16'd1;
        idx_full   = r_taken - TW'(1);
        last       = (r_skip <= 16'd1);
        name_vld   = 1'b0;
        name_res   = '0;

        unique case (r_phase)
            PH_SCAN: begin
                n_window = {r_window[23:0], i_data_byte};
                if (r_fill < 3'd4) begin
                    n_fill = r_fill + 3'd1;
                end
                if (r_fill >= 3'd3 && n_window == SIGNATURE) begin
                    n_phase = PH_SKIP;
                    n_skip  = HEADER_SKIP;
                end
            end
            PH_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == 16'd0) begin
                    n_phase = PH_NLO;
                end
            end
            PH_NLO: begin
                n_name_len = {8'h00, i_data_byte};
                n_phase    = PH_NHI;
            end
            PH_NHI: begin
                n_name_len = {i_data_byte, r_name_len[7:0]};
                n_phase    = PH_XLO;
            end
            PH_XLO: begin
                n_extra = {8'h00, i_data_byte};
                n_phase = PH_XHI;
            end
            PH_XHI: begin
                n_extra    = {i_data_byte, r_extra[7:0]};
                n_accepted = (r_name_len != 16'd0) && ({1'b0, r_name_len} < NAME_LIM)
                             && (r_taken < MAX_ENT);
                if (n_accepted) begin
                    n_taken = r_taken + TW'(1);
                end
                if (r_name_len != 16'd0) begin
                    n_phase = PH_NAME;
                    n_skip  = r_name_len;
                end else if (n_extra != 16'd0) begin
                    n_phase = PH_EXTRA;
                    n_skip  = n_extra;
                end else begin
                    n_phase  = PH_SCAN;
                    n_window = '0;
                    n_fill   = '0;
                end
            end
            PH_NAME: begin
                if (r_accepted) begin
                    name_vld             = 1'b1;
                    name_res.kind        = KIND_NAME;
                    name_res.name_byte   = i_data_byte;
                    name_res.entry_index = idx_full[7:0];
                    name_res.name_last   = last | i_end_of_stream;
                end
                n_skip = skip_dec;
                if (last) begin
                    n_accepted = 1'b0;
                    if (r_extra != 16'd0) begin
                        n_phase = PH_EXTRA;
                        n_skip  = r_extra;
                    end else begin
                        n_phase  = PH_SCAN;
                        n_window = '0;
                        n_fill   = '0;
                    end
                end
            end
            PH_EXTRA: begin
                n_skip = skip_dec;
                if (skip_dec == 16'd0) begin
                    n_phase  = PH_SCAN;
                    n_window = '0;
                    n_fill   = '0;
                end
            end
        endcase

        count_res             = '0;
        count_res.kind        = KIND_COUNT;
        count_res.entry_count = n_taken[8:0];

        // end of stream returns everything to its reset values
        if (i_end_of_stream) begin
            n_phase    = PH_SCAN;
            n_window   = '0;
            n_fill     = '0;
            n_skip     = '0;
            n_name_len = '0;
            n_extra    = '0;
            n_taken    = '0;
            n_accepted = 1'b0;
        end

        o_push = '0;
        if (name_vld) begin
            o_push.first  = name_res;
            o_push.second = count_res;
            o_push.cnt    = i_end_of_stream ? 2'd2 : 2'd1;
        end else begin
            o_push.first  = count_res;
            o_push.cnt    = {1'b0, i_end_of_stream};
        end
        if (!i_take) begin
            o_push.cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SCAN;
            r_window   <= '0;
            r_fill     <= '0;
            r_skip     <= '0;
            r_name_len <= '0;
            r_extra    <= '0;
            r_taken    <= '0;
            r_accepted <= 1'b0;
        end else if (i_take) begin
            r_phase    <= n_phase;
            r_window   <= n_window;
            r_fill     <= n_fill;
            r_skip     <= n_skip;
            r_name_len <= n_name_len;
            r_extra    <= n_extra;
            r_taken    <= n_taken;
            r_accepted <= n_accepted;
        end
    end

    a_name_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_NAME |-> r_skip != 16'd0)
        else $error("name phase with no bytes left");

    a_taken_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_taken <= MAX_ENT)
        else $error("names taken beyond limit");

    a_eos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_end_of_stream |=> r_phase == PH_SCAN && r_taken == '0 && !r_accepted)
        else $error("state not cleared after end of stream");

endmodule

`default_nettype wire

@@ hw/rtl/zlx_out_fifo.sv @@
`default_nettype none

module zlx_out_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire zlx_pkg::t_push i_push,
    input  wire logic           i_stall,
    output logic                o_valid,
    output logic                o_room,
    output zlx_pkg::t_result    o_result
);
    import zlx_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    t_result       r_mem [FIFO_DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [PW:0]   r_count, n_count;
    logic [PW-1:0] wr_next;
    logic          pop;

    assign o_valid  = (r_count != '0);
    assign o_room   = (r_count <= (PW+1)'(FIFO_DEPTH - 2));
    assign o_result = r_mem[r_rd];
    assign pop      = o_valid && !i_stall;
    assign wr_next  = r_wr + PW'(1);

    always_comb begin
        n_wr    = r_wr + PW'(i_push.cnt);
        n_rd    = r_rd + PW'(pop);
        n_count = r_count + (PW+1)'(i_push.cnt) - (PW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_next] <= i_push.second;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.cnt != 2'd0 |-> o_room)
        else $error("result written without room");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PW+1)'(FIFO_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

@@ hw/rtl/zip_local_header_name_extractor.sv @@
// a result enters the result queue in the cycle after its byte is accepted
// throughput: one byte per cycle when not stalled; parser step is the only loop
// a final byte ending a name yields two results, drained one per unstalled cycle
// input stalls while the four-entry result queue has fewer than two free slots
// reset: synchronous active low, clears the parser state and empties the queue
`default_nettype none

module zip_local_header_name_extractor #(
    parameter int MAX_ENTRIES = zlx_pkg::DEF_MAX_ENTRIES,
    parameter int NAME_LIMIT  = zlx_pkg::DEF_NAME_LIMIT
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // byte request channel
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_end_of_stream,
    // result request channel
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_kind,
    output logic [7:0]      o_name_byte,
    output logic [7:0]      o_entry_index,
    output logic            o_name_last,
    output logic [8:0]      o_entry_count
);
    import zlx_pkg::*;

    t_push   push;
    t_result result;
    logic    room;
    logic    take;

    // a byte is taken only when the queue can hold both results it may cause
    assign o_stall = !room;
    assign take    = i_valid && room;

    // header walker: signature window, skip counters, length capture
    zlx_parser #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .NAME_LIMIT  (NAME_LIMIT)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_push          (push)
    );

    // result queue decouples the two sides
    zlx_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_room   (room),
        .o_result (result)
    );

    assign o_kind        = result.kind;
    assign o_name_byte   = result.name_byte;
    assign o_entry_index = result.entry_index;
    assign o_name_last   = result.name_last;
    assign o_entry_count = result.entry_count;

endmodule

`default_nettype wire
